[sv/fpla_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpla_pkg
// Constants, coefficient tables and the shared Horner step for the
// fixed-point log-add pipeline.
// ----------------------------------------------------------------------------
package fpla_pkg;

  // Pipeline depth: order, scale, split, four 2^x steps, rescale,
  // four ln(1+x) steps, final sum
  localparam int unsigned NUM_STAGES = 13;

  // log2(e) in Q14
  localparam logic [14:0] LOG2E_Q14 = 15'd23637;
  // ln(2) in Q15, used when the ln(1+x) argument is exactly one
  localparam logic signed [15:0] LN2_Q15 = 16'sd22713;
  // Largest distance (Q6) at which the smaller value still contributes
  localparam logic [15:0] FAR_LIMIT = 16'd448;
  // Upper saturation bound of the result
  localparam logic signed [16:0] SUM_MAX = 17'sd32767;
  // Exact one in unsigned Q15
  localparam logic [15:0] ONE_Q15 = 16'h8000;

  // 2^x polynomial, highest order first, Q14
  localparam logic signed [15:0] POW2_POLY [5] = '{
    16'sd158, 16'sd909, 16'sd3936, 16'sd11357, 16'sd16384
  };
  // ln(1+x) polynomial, highest order first, Q15
  localparam logic signed [15:0] LN1P_POLY [5] = '{
    -16'sd1801, 16'sd7104, -16'sd15220, 16'sd32623, 16'sd4
  };

  // One Horner step: (acc * x + c * 2^15 + 2^14) >> 15, wrapped to 16 bits
  function automatic logic signed [15:0] horner_step(
    input logic signed [15:0] acc,
    input logic signed [15:0] x,
    input logic signed [15:0] c
  );
    logic signed [33:0] prod;
    logic signed [33:0] sum;
    prod = 34'(acc) * 34'(x);
    sum  = prod + (34'(c) <<< 15) + 34'sd16384;
    return sum[30:15];
  endfunction

endpackage

[sv/fixed_point_log_add_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_log_add_core
// Log-domain addition ln(e^a + e^b) of two signed Q6 values.
// ----------------------------------------------------------------------------
// The core accepts one pair of Q6 log values per clock cycle while its
// input is not stalled and presents one Q6 result per pair, in order,
// from the output register. Each of the 13 register stages holds at
// most one 16x16 multiplier or one add and compare: the log2(e) scaling,
// four Horner steps for 2^x, the power-of-two rescale, four Horner steps
// for ln(1+x) and the final rounding add. Every stage has its own valid bit
// and moves forward whenever the stage ahead of it is empty or moving, so
// bubbles close up and input is still taken while a result waits at the
// output. Pairs that lie more than 7.0 apart return the larger value.
// ----------------------------------------------------------------------------
module fixed_point_log_add_core
  import fpla_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] first_log_i,
  input  logic signed [15:0] second_log_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] sum_log_o
);

  // Stage control
  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] valid_d;
  logic [NUM_STAGES-1:0] adv;

  // Larger value and far flag, carried through stages 0 to 11
  logic signed [15:0] hi_q  [NUM_STAGES-1];
  logic signed [15:0] hi_d  [NUM_STAGES-1];
  logic               far_q [NUM_STAGES-1];
  logic               far_d [NUM_STAGES-1];

  // Stage 0: distance, stage 1: scaled distance
  logic [8:0]  negd_q;
  logic [8:0]  negd_d;
  logic [23:0] t_q;
  logic [23:0] t_d;

  // Stage 2: centred fraction and shift amount
  logic signed [15:0] frac_q;
  logic signed [15:0] frac_d;

  // Shift amount, carried through stage 2 and the 2^x stages
  logic [3:0] k_q [5];
  logic [3:0] k_d [5];

  // 2^x Horner stages
  logic signed [15:0] pw_acc_q [4];
  logic signed [15:0] pw_acc_d [4];
  logic signed [15:0] pw_x_q   [4];
  logic signed [15:0] pw_x_d   [4];

  // Stage 7: e^d in unsigned Q15
  logic [15:0] e_q;
  logic [15:0] e_d;

  // ln(1+x) Horner stages
  logic signed [15:0] ln_acc_q [4];
  logic signed [15:0] ln_acc_d [4];
  logic signed [15:0] ln_x_q   [4];
  logic signed [15:0] ln_x_d   [4];
  logic               one_q    [4];
  logic               one_d    [4];

  // Stage 12: output register
  logic signed [15:0] sum_q;
  logic signed [15:0] sum_d;

  // Stage 0 working signals
  logic signed [16:0] diff_ab;
  logic signed [16:0] diff_ba;
  logic               swap;
  logic [16:0]        absd;

  // Stage 2 working signals
  logic [3:0]  ipart;
  logic [20:0] f_sum;
  logic [15:0] f_val;
  logic [15:0] frac_c;
  logic        frac_big;

  // Stage 7 working signals
  logic [31:0] prod_sh;
  logic [31:0] prod_rnd;

  // Stage 12 working signals
  logic signed [15:0] ln_val;
  logic signed [25:0] s_sum;
  logic signed [16:0] s_shr;

  // Advance a stage when it is empty or the stage ahead moves
  always_comb begin
    adv[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || !out_stall_i;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      adv[i] = !valid_q[i] || adv[i+1];
    end
    valid_d[0] = adv[0] ? in_valid_i : valid_q[0];
    for (int i = 1; i < NUM_STAGES; i++) begin
      valid_d[i] = adv[i] ? valid_q[i-1] : valid_q[i];
    end
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = valid_q[NUM_STAGES-1];
  assign sum_log_o   = sum_q;

  // Stage 0: order the pair and measure the distance
  always_comb begin
    diff_ab  = 17'(first_log_i) - 17'(second_log_i);
    diff_ba  = 17'(second_log_i) - 17'(first_log_i);
    swap     = diff_ab[16];
    absd     = swap ? diff_ba : diff_ab;
    negd_d   = absd[8:0];
  end

  // Carry the larger value and far flag down the pipeline
  always_comb begin
    hi_d[0]  = swap ? second_log_i : first_log_i;
    far_d[0] = absd[15:0] > FAR_LIMIT;
    for (int i = 1; i < NUM_STAGES - 1; i++) begin
      hi_d[i]  = hi_q[i-1];
      far_d[i] = far_q[i-1];
    end
  end

  // Stage 1: scale the distance by log2(e), Q20
  always_comb begin
    t_d = {9'd0, LOG2E_Q14} * {15'd0, negd_q};
  end

  // Stage 2: split into shift and a fraction centred on zero
  always_comb begin
    ipart    = t_q[23:20];
    f_sum    = {1'b0, t_q[19:0]} + 21'd16;
    f_val    = f_sum[20:5];
    frac_big = !f_val[15] && f_val[14];
    if (frac_big) begin
      k_d[0] = 4'd14 - ipart;
      frac_c = f_val - ONE_Q15;
    end else begin
      k_d[0] = 4'd15 - ipart;
      frac_c = f_val;
    end
    frac_d   = signed'(16'd0 - frac_c);
    // Carry the shift amount through the 2^x stages
    for (int j = 1; j < 5; j++) begin
      k_d[j] = k_q[j-1];
    end
  end

  // Stages 3 to 6: Horner steps for 2^x
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (j == 0) begin
        pw_acc_d[j] = horner_step(POW2_POLY[0], frac_q, POW2_POLY[1]);
        pw_x_d[j]   = frac_q;
      end else begin
        pw_acc_d[j] = horner_step(pw_acc_q[j-1], pw_x_q[j-1], POW2_POLY[j+1]);
        pw_x_d[j]   = pw_x_q[j-1];
      end
    end
  end

  // Stage 7: apply the power-of-two scale and round to Q15
  always_comb begin
    prod_sh  = {16'd0, pw_acc_q[3]} << k_q[4];
    prod_rnd = prod_sh + 32'd8192;
    e_d      = prod_rnd[29:14];
  end

  // Stages 8 to 11: Horner steps for ln(1+x)
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (j == 0) begin
        ln_acc_d[j] = horner_step(LN1P_POLY[0], signed'(e_q), LN1P_POLY[1]);
        ln_x_d[j]   = signed'(e_q);
        one_d[j]    = e_q == ONE_Q15;
      end else begin
        ln_acc_d[j] = horner_step(ln_acc_q[j-1], ln_x_q[j-1], LN1P_POLY[j+1]);
        ln_x_d[j]   = ln_x_q[j-1];
        one_d[j]    = one_q[j-1];
      end
    end
  end

  // Stage 12: add the larger value, round to Q6 and saturate high
  always_comb begin
    ln_val = one_q[3] ? LN2_Q15 : ln_acc_q[3];
    s_sum  = 26'(ln_val) + (26'(hi_q[11]) <<< 9) + 26'sd256;
    s_shr  = s_sum[25:9];
    if (far_q[11]) begin
      sum_d = hi_q[11];
    end else if (s_shr > SUM_MAX) begin
      sum_d = SUM_MAX[15:0];
    end else begin
      sum_d = s_shr[15:0];
    end
  end

  // Hold valid bits under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Advance payload registers with their stage
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_STAGES - 1; i++) begin
      if (adv[i]) begin
        hi_q[i]  <= hi_d[i];
        far_q[i] <= far_d[i];
      end
    end
    if (adv[0]) begin
      negd_q <= negd_d;
    end
    if (adv[1]) begin
      t_q <= t_d;
    end
    if (adv[2]) begin
      frac_q <= frac_d;
      k_q[0] <= k_d[0];
    end
    for (int j = 0; j < 4; j++) begin
      if (adv[j+3]) begin
        pw_acc_q[j] <= pw_acc_d[j];
        pw_x_q[j]   <= pw_x_d[j];
        k_q[j+1]    <= k_d[j+1];
      end
      if (adv[j+8]) begin
        ln_acc_q[j] <= ln_acc_d[j];
        ln_x_q[j]   <= ln_x_d[j];
        one_q[j]    <= one_d[j];
      end
    end
    if (adv[7]) begin
      e_q <= e_d;
    end
    if (adv[NUM_STAGES-1]) begin
      sum_q <= sum_d;
    end
  end

`ifndef SYNTH
  // Input is held off only when every stage is occupied
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q))
    else $error("input stalled with an empty stage");

  // An input transfer always lands in stage 0
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> valid_q[0])
    else $error("accepted pair did not enter stage 0");

  // Near pairs give a shift of at least four
  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[2] && !far_q[2]) |-> (k_q[0] >= 4'd4))
    else $error("shift amount out of range");
`endif

endmodule

[tb/sv/fixed_point_log_add_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_log_add_core_tb
// Self-checking bench for the Q6 log-domain addition pipeline.
// ----------------------------------------------------------------------------
// Pairs of Q6 log values are driven through the valid/stall input channel.
// Each accepted pair is scored by a bit-accurate model of the log-add
// datapath and queued. Every result taken from the output channel is
// compared in order against the queue. Stimulus opens with hand-picked
// pairs, sweeps every distance from equal to just past the far-apart
// cut-off, then runs random pairs. Both sides idle in short random bursts;
// once the receiver holds off long enough to back the pipeline up.
// ----------------------------------------------------------------------------
module fixed_point_log_add_core_tb;
  import fpla_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_PAIRS = 1100;
  localparam int unsigned QUIET_TAIL = 200;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned HOLD_AT = 300;

  // --------------------------------------------------------------------------
  // Expected-sum tracker: models the datapath and checks results in order
  // --------------------------------------------------------------------------
  class log_sum_scoreboard;
    logic signed [15:0] pending_sums[$];
    int unsigned mismatches = 0;

    function logic signed [15:0] wrap16(longint v);
      return v[15:0];
    endfunction

    // Four Horner steps, every step wrapped to 16 bits
    function logic signed [15:0] run_horner(bit ln_sel, logic signed [15:0] x);
      logic signed [15:0] acc;
      longint t;
      int k;
      acc = ln_sel ? LN1P_POLY[0] : POW2_POLY[0];
      for (k = 1; k < 5; k++) begin
        t = longint'(acc) * longint'(x)
          + longint'(ln_sel ? LN1P_POLY[k] : POW2_POLY[k]) * 32768 + 16384;
        acc = wrap16(t >>> 15);
      end
      return acc;
    endfunction

    function logic signed [15:0] predict_sum(logic signed [15:0] a,
                                             logic signed [15:0] b);
      logic signed [15:0] big;
      logic signed [15:0] tiny;
      logic signed [15:0] frac;
      logic signed [15:0] pw;
      logic signed [15:0] ln1p;
      logic [15:0] ex;
      logic [31:0] scale;
      logic [31:0] prod;
      longint scaled;
      longint tmp;
      longint s;
      int diff;
      int shift;
      big  = (a < b) ? b : a;
      tiny = (a < b) ? a : b;
      diff = int'(tiny) - int'(big);
      // Far apart: the smaller value does not contribute
      if (diff < -int'(FAR_LIMIT))
        return big;
      // e^diff as unsigned Q15 via 2^(diff * log2 e)
      scaled = -(longint'(LOG2E_Q14) * longint'(diff));
      shift = int'(scaled >>> 20);
      if (shift >= 16) begin
        ex = '0;
      end else begin
        scale = 32'd32768 >> shift;
        tmp = ((scaled & 64'hFFFFF) + 16) >>> 5;
        // A fraction of one wraps to the most negative value
        frac = tmp[15:0];
        if (frac >= 16384) begin
          scale = scale >> 1;
          frac = wrap16(longint'(frac) - 32768);
        end
        frac = wrap16(-longint'(frac));
        pw = run_horner(1'b0, frac);
        prod = scale * {16'h0000, pw};
        prod = prod + 32'd8192;
        ex = prod[29:14];
      end
      // ln(1 + e^diff), exact one maps to ln 2
      ln1p = (ex == ONE_Q15) ? LN2_Q15 : run_horner(1'b1, signed'(ex));
      s = (longint'(ln1p) + longint'(big) * 512 + 256) >>> 9;
      if (s > longint'(SUM_MAX))
        s = longint'(SUM_MAX);
      return wrap16(s);
    endfunction

    function void note_pair(logic signed [15:0] a, logic signed [15:0] b);
      pending_sums.push_back(predict_sum(a, b));
    endfunction

    function void check_sum(logic signed [15:0] actual);
      logic signed [15:0] want;
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected sum_log, expected none, actual %0d", $time, actual);
        mismatches++;
        return;
      end
      want = pending_sums.pop_front();
      if (actual !== want) begin
        $display("%0t: sum_log mismatch, expected %0d, actual %0d", $time, want, actual);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [15:0] first_log_i;
  logic signed [15:0] second_log_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [15:0] sum_log_o;

  log_sum_scoreboard tracker;
  bit idle_on = 1'b1;
  bit long_hold_req = 1'b0;

  fixed_point_log_add_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .first_log_i  (first_log_i),
    .second_log_i (second_log_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sum_log_o    (sum_log_o)
  );

  // Free-running clock
  always #2 clk_i = ~clk_i;

  // Score every input transfer
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      tracker.note_pair(first_log_i, second_log_i);
  end

  // Check every output transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.check_sum(sum_log_o);
  end

  // Drive output stall: random bursts, plus one long hold-off on request
  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left == 0) begin
        if (long_hold_req) begin
          stall_left = HOLD_CYCLES;
          long_hold_req = 1'b0;
        end else if (idle_on && rst_ni && $urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 7);
        end
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Abort a run that stops making progress
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Offer one pair and hold it until the transfer completes
  task automatic send_pair(input logic signed [15:0] a, input logic signed [15:0] b);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    first_log_i  <= a;
    second_log_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Offer a pair a given distance apart, larger value in [top_min, top_max]
  task automatic send_near(input int top_min, input int top_max, input int span);
    int big;
    int tiny;
    big = top_min + int'($urandom_range(0, top_max - top_min));
    tiny = big - span;
    if ($urandom_range(0, 1))
      send_pair(16'(big), 16'(tiny));
    else
      send_pair(16'(tiny), 16'(big));
  endtask

  initial begin : stimulus
    int unsigned sel;
    int d;
    int unsigned n;
    tracker = new();
    in_valid_i   <= 1'b0;
    first_log_i  <= '0;
    second_log_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pairs: extremes, equal values, cut-off edges, saturation
    send_pair(16'sd0, 16'sd0);
    send_pair(16'sd32767, 16'sd32767);
    send_pair(-16'sd32768, -16'sd32768);
    send_pair(16'sd32767, -16'sd32768);
    send_pair(-16'sd32768, 16'sd32767);
    send_pair(16'sd0, -16'sd448);
    send_pair(-16'sd448, 16'sd0);
    send_pair(16'sd0, -16'sd449);
    send_pair(-16'sd449, 16'sd0);
    send_pair(16'sd32767, 16'sd32319);
    send_pair(16'sd32767, 16'sd32318);
    send_pair(16'sd32767, 16'sd32766);
    send_pair(16'sd32700, 16'sd32700);
    send_pair(-16'sd32320, -16'sd32768);
    send_pair(-16'sd32768, -16'sd32767);
    send_pair(16'sd64, 16'sd0);
    send_pair(16'sd1, 16'sd0);
    send_pair(-16'sd1, 16'sd0);
    send_pair(16'sd100, -16'sd348);
    send_pair(16'sd21845, -16'sd21846);
    send_pair(16'h5555, 16'h5555);
    send_pair(-16'sd21846, -16'sd21846);

    // Sweep every distance up to the cut-off and a little past it
    for (d = 0; d <= 460; d++)
      send_near(-32300, 32767, d);

    // Random pairs, mostly within reach of each other
    for (n = 0; n < RANDOM_PAIRS; n++) begin
      if (n == HOLD_AT)
        long_hold_req = 1'b1;
      if (n == RANDOM_PAIRS - QUIET_TAIL)
        idle_on = 1'b0;
      sel = $urandom_range(0, 9);
      if (sel < 5)
        send_near(-32300, 32767, $urandom_range(0, 448));
      else if (sel < 6)
        send_near(32167, 32767, $urandom_range(0, 448));
      else if (sel < 7)
        send_near(-32300, -32100, $urandom_range(0, 448));
      else if (sel < 8)
        send_near(-32300, 32767, $urandom_range(440, 460));
      else
        send_pair(16'($urandom()), 16'($urandom()));
    end
    in_valid_i <= 1'b0;

    // Drain the pipeline, then keep watching the output for strays
    while (tracker.pending_sums.size() != 0) @(posedge clk_i);
    repeat (2 * NUM_STAGES) @(posedge clk_i);

    if (tracker.mismatches == 0 && tracker.pending_sums.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
